[sv/mfr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the frame receiver.
// Used by every module of the block; depends on nothing.
package mfr_pkg;

  localparam logic [7:0]  SENTINEL       = 8'h24;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd2048;
  localparam logic [8:0]  HUNT_LIMIT_RST = 9'd256;
  localparam logic [15:0] SWALLOW_BYTES  = 16'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic REG_MAX_LENGTH = 1'b0;
  localparam logic REG_HUNT_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_SWALLOW  = 3'd1,
    PH_CHECKSUM = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_LEN_LO   = 3'd4,
    PH_PAYLOAD  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_TOOLONG = 3'd3,
    KIND_BADHDR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[sv/mfr_regs.sv]
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on mfr_pkg for reset values and register indexes.
module mfr_regs import mfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_length,
  output logic [8:0]  hunt_limit
);

  logic wr_en;
  logic sel;

  assign pready = 1'b1;
  assign sel    = paddr[2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
      hunt_limit <= HUNT_LIMIT_RST;
    end else if (wr_en) begin
      case (sel)
        REG_MAX_LENGTH: max_length <= pwdata[15:0];
        REG_HUNT_LIMIT: hunt_limit <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_MAX_LENGTH: prdata = {16'd0, max_length};
      REG_HUNT_LIMIT: prdata = {23'd0, hunt_limit};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

[sv/mfr_parser.sv]
`timescale 1ns / 1ps
// Frame parser: hunt, swallow, header, payload phases and the results of each byte.
// Depends on mfr_pkg for phase, kind and result types.
module mfr_parser import mfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_length,
  input  logic [8:0]  hunt_limit,
  output push_t       push
);

  phase_t      phase, phase_next;
  logic [8:0]  miss_count, miss_count_next;
  logic [7:0]  sent_checksum, sent_checksum_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;

  logic [8:0]  miss_inc;
  logic [15:0] left_dec;
  logic [15:0] frame_length;
  logic [7:0]  sum_add;

  assign miss_inc     = miss_count + 9'd1;
  assign left_dec     = bytes_left - 16'd1;
  assign frame_length = {len_hi, rx_byte};
  assign sum_add      = running_sum + rx_byte;

  always_comb begin
    phase_next         = phase;
    miss_count_next    = miss_count;
    sent_checksum_next = sent_checksum;
    len_hi_next        = len_hi;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    case (phase)
      PH_SWALLOW: begin
        bytes_left_next = left_dec;
        if (left_dec == 16'd0) begin
          phase_next      = PH_HUNT;
          miss_count_next = 9'd0;
        end
      end
      PH_CHECKSUM: begin
        sent_checksum_next = rx_byte;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_hi_next = rx_byte;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        running_sum_next = 8'd0;
        if (frame_length > max_length || frame_length == 16'd0) begin
          phase_next = PH_HUNT;
        end else begin
          bytes_left_next = frame_length;
          phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = sum_add;
        bytes_left_next  = left_dec;
        if (left_dec == 16'd0) phase_next = PH_HUNT;
      end
      default: begin
        if (rx_byte == SENTINEL) begin
          miss_count_next = 9'd0;
          phase_next      = PH_CHECKSUM;
        end else if (miss_inc >= hunt_limit || miss_inc == 9'd0) begin
          miss_count_next = 9'd0;
          bytes_left_next = SWALLOW_BYTES;
          phase_next      = PH_SWALLOW;
        end else begin
          miss_count_next = miss_inc;
          phase_next      = PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    push.count  = 2'd0;
    push.first  = '{kind: KIND_DATA, payload: 8'd0, frame_end: 1'b0};
    push.second = '{kind: KIND_DATA, payload: 8'd0, frame_end: 1'b0};
    case (phase)
      PH_SWALLOW: begin
        if (left_dec == 16'd0) begin
          push.count = 2'd1;
          push.first = '{kind: KIND_BADHDR, payload: 8'd0, frame_end: 1'b1};
        end
      end
      PH_LEN_LO: begin
        if (frame_length > max_length) begin
          push.count = 2'd1;
          push.first = '{kind: KIND_TOOLONG, payload: 8'd0, frame_end: 1'b1};
        end else if (frame_length == 16'd0) begin
          push.count = 2'd1;
          push.first = '{kind: (sent_checksum == 8'd0) ? KIND_GOOD : KIND_BADSUM,
                         payload: 8'd0, frame_end: 1'b1};
        end
      end
      PH_PAYLOAD: begin
        push.first = '{kind: KIND_DATA, payload: rx_byte, frame_end: 1'b0};
        if (left_dec == 16'd0) begin
          push.count  = 2'd2;
          push.second = '{kind: (sum_add == sent_checksum) ? KIND_GOOD : KIND_BADSUM,
                          payload: 8'd0, frame_end: 1'b1};
        end else begin
          push.count = 2'd1;
        end
      end
      default: ;
    endcase
    if (!take) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      miss_count    <= 9'd0;
      sent_checksum <= 8'd0;
      len_hi        <= 8'd0;
      bytes_left    <= 16'd0;
      running_sum   <= 8'd0;
    end else if (take) begin
      phase         <= phase_next;
      miss_count    <= miss_count_next;
      sent_checksum <= sent_checksum_next;
      len_hi        <= len_hi_next;
      bytes_left    <= bytes_left_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

[sv/mfr_out_queue.sv]
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one.
// Depends on mfr_pkg for the result types and queue depth.
module mfr_out_queue import mfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output logic    full,
  output logic    res_valid,
  output result_t head
);

  result_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W-1:0]   wr_ptr_inc;
  logic [QCNT_W-1:0]   count, count_next;

  assign wr_ptr_inc = wr_ptr + QPTR_W'(1);
  assign res_valid  = (count != QCNT_W'(0));
  assign full       = (count > QCNT_W'(QDEPTH - 2));
  assign head       = entries[rd_ptr];
  assign count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr_inc] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

endmodule

[sv/mailbox_frame_receiver.sv]
`timescale 1ns / 1ps
// Frame receiver top level: config registers, parser and result queue.
// Results of an accepted byte are registered in a four-entry queue, offered in order.
// Takes one byte per cycle while rx_stall is low; the last payload byte yields two results,
// drained one per cycle unless stalled; rx_stall rises when the queue holds more than two.
// Reset (synchronous): hunting phase, counters and queue cleared, registers to defaults.
module mailbox_frame_receiver import mfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_length;
  logic [8:0]  hunt_limit;
  logic        full;
  logic        take;
  push_t       push;
  result_t     head;

  assign rx_stall  = full;
  assign take      = rx_valid & ~full;
  assign kind      = head.kind;
  assign payload   = head.payload;
  assign frame_end = head.frame_end;

  mfr_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .max_length, .hunt_limit
  );

  mfr_parser u_parser (
    .clk, .rst, .take, .rx_byte, .max_length, .hunt_limit, .push
  );

  mfr_out_queue u_queue (
    .clk, .rst, .push, .pop(res_valid & ~res_stall), .full, .res_valid, .head
  );

endmodule

[sv/mfr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the frame receiver, bound to the top level.
// Depends on mfr_pkg for result kind codes.
module mfr_checker import mfr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] kind,
  input logic [7:0] payload,
  input logic       frame_end
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(payload)
                               && $stable(frame_end))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !rx_stall)
    else $error("not empty after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !rx_stall)
    else $error("request stalled with empty queue");

  a_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind == KIND_DATA && !frame_end)
               || ((kind == KIND_GOOD || kind == KIND_BADSUM || kind == KIND_TOOLONG
                    || kind == KIND_BADHDR) && frame_end && payload == 8'd0))
    else $error("malformed result");

endmodule

bind mailbox_frame_receiver mfr_checker u_chk (.*);
